FILE: design/dsu_pkg.sv
`default_nettype none

package dsu_pkg;

	// Table size and derived widths
	localparam int NUM_ELEMENTS = 1024;
	localparam int IDX_W        = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam int ELEM_W       = 10;
	localparam int RANK_W       = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [RANK_W-1:0] rank_t;

	// One table entry: parent link and rank share a word
	typedef struct packed {
		idx_t  parent;
		rank_t rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic start_a;
		logic start_b;
		logic hop;
		logic cap_a;
		logic cap_b;
		logic link_wr;
		logic bump_wr;
		logic clr_wr;
		logic out_load;
	} dsu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_range;
		logic op_union;
		logic at_root;
		logic clr_done;
		logic roots_eq;
		logic rank_tie;
		logic out_full;
	} dsu_sts_t;

	// Map an element number onto a table address
	function automatic idx_t to_idx(elem_t e);
		return IDX_W'(e);
	endfunction

endpackage

`default_nettype wire

FILE: design/dsu_ram.sv
`default_nettype none

module dsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]                 wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
	output      logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: design/dsu_ctrl.sv
`default_nettype none

module dsu_ctrl import dsu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_ready,
	input  wire dsu_sts_t sts,
	output      dsu_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_WALK_A = 8'b0000_1000,
		S_WALK_B = 8'b0001_0000,
		S_LINK   = 8'b0010_0000,
		S_BUMP   = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.in_range) begin
					cmd.start_a = 1'b1;
					state_d     = S_WALK_A;
				end else if (sts.op_union) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_RESP;
				end
			end
			S_WALK_A: begin
				if (sts.at_root) begin
					cmd.cap_a   = 1'b1;
					cmd.start_b = 1'b1;
					state_d     = S_WALK_B;
				end else begin
					cmd.hop = 1'b1;
				end
			end
			S_WALK_B: begin
				if (sts.at_root) begin
					cmd.cap_b = 1'b1;
					state_d   = sts.op_union ? S_LINK : S_RESP;
				end else begin
					cmd.hop = 1'b1;
				end
			end
			S_LINK: begin
				if (sts.roots_eq) begin
					state_d = S_IDLE;
				end else begin
					cmd.link_wr = 1'b1;
					state_d     = sts.rank_tie ? S_BUMP : S_IDLE;
				end
			end
			S_BUMP: begin
				cmd.bump_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_RESP: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/dsu_dp.sv
`default_nettype none

module dsu_dp import dsu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     op,
	input  wire elem_t    first_element,
	input  wire elem_t    second_element,
	output      logic     out_valid,
	input  wire logic     out_ready,
	output      logic     same_set,
	input  wire dsu_cmd_t cmd,
	output      dsu_sts_t sts
);

	logic   op_q;
	elem_t  a_q, b_q;
	idx_t   cur_q;
	idx_t   root_a_q, root_b_q;
	rank_t  rank_a_q, rank_b_q;
	idx_t   clr_q;
	logic   out_valid_q;
	logic   same_q;

	idx_t   rd_addr;
	idx_t   wr_addr;
	entry_t wr_entry;
	entry_t rd_entry;
	logic   wr_en;
	logic   in_range;
	logic   same_now;
	logic [ENTRY_W-1:0] rd_raw;

	dsu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_ELEMENTS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);
	assign in_range = (32'(a_q) < NUM_ELEMENTS) && (32'(b_q) < NUM_ELEMENTS);
	assign same_now = in_range ? (root_a_q == root_b_q) : (a_q == b_q);

	// Read address: start of a walk, one hop up, or hold
	always_comb begin
		if (cmd.start_a) begin
			rd_addr = to_idx(a_q);
		end else if (cmd.start_b) begin
			rd_addr = to_idx(b_q);
		end else if (cmd.hop) begin
			rd_addr = rd_entry.parent;
		end else begin
			rd_addr = cur_q;
		end
	end

	// Write port: clearing sweep, link, rank bump
	always_comb begin
		wr_en    = cmd.clr_wr | cmd.link_wr | cmd.bump_wr;
		wr_addr  = clr_q;
		wr_entry = '{parent: clr_q, rank: '0};
		if (cmd.link_wr) begin
			if (rank_a_q < rank_b_q) begin
				wr_addr  = root_a_q;
				wr_entry = '{parent: root_b_q, rank: rank_a_q};
			end else begin
				wr_addr  = root_b_q;
				wr_entry = '{parent: root_a_q, rank: rank_b_q};
			end
		end else if (cmd.bump_wr) begin
			wr_addr  = root_a_q;
			wr_entry = '{parent: root_a_q,
				rank: (rank_a_q == RANK_MAX) ? RANK_MAX : rank_a_q + 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= op;
			a_q  <= first_element;
			b_q  <= second_element;
		end
		if (cmd.start_a || cmd.start_b || cmd.hop) begin
			cur_q <= rd_addr;
		end
		if (cmd.cap_a) begin
			root_a_q <= cur_q;
			rank_a_q <= rd_entry.rank;
		end
		if (cmd.cap_b) begin
			root_b_q <= cur_q;
			rank_b_q <= rd_entry.rank;
		end
		if (cmd.out_load) begin
			same_q <= same_now;
		end
	end

	assign sts.in_range = in_range;
	assign sts.op_union = op_q;
	assign sts.at_root  = (rd_entry.parent == cur_q);
	assign sts.clr_done = (clr_q == IDX_W'(NUM_ELEMENTS - 1));
	assign sts.roots_eq = (root_a_q == root_b_q);
	assign sts.rank_tie = (rank_a_q == rank_b_q);
	assign sts.out_full = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;
	assign same_set  = same_q;

endmodule

`default_nettype wire

FILE: design/disjoint_set_union_by_rank.sv
// Union-find table with union by rank over NUM_ELEMENTS elements (1024).
// Each input transfer carries op (0 = query, 1 = union) and two element
// numbers. A query returns one output transfer, same_set, which is 1 when
// both elements have the same root; a union returns nothing. Indices at or
// above NUM_ELEMENTS act as fixed singletons: a union naming one is
// dropped, a query naming one reports whether the two indices are equal.
// Parent link and rank live together in one single-port-read table RAM with
// a registered read, and each step of a root walk is one read of that RAM,
// so an item occupies the block through both root walks, one step per hop
// from each element to its root (at most about ten hops with 1024
// elements), plus the rank bump write after an equal-rank link.
// Out-of-range items skip both root walks. A query also waits in its
// response state while an earlier result sits in the output register.
// After reset a clearing pass writes every entry (parent = own index,
// rank = 0); in_ready stays low until it is finished. A query result sits
// in an output register, so the next item may be taken while it waits
// for out_ready.
`default_nettype none

module disjoint_set_union_by_rank import dsu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output      logic  in_ready,
	input  wire logic  op,
	input  wire elem_t first_element,
	input  wire elem_t second_element,
	output      logic  out_valid,
	input  wire logic  out_ready,
	output      logic  same_set
);

	dsu_cmd_t cmd;
	dsu_sts_t sts;

	// Sequencer: clearing pass, two root walks, link or response
	dsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Item registers, walk pointer, captured roots, table RAM, output register
	dsu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.first_element (first_element),
		.second_element(second_element),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.same_set      (same_set),
		.cmd           (cmd),
		.sts           (sts)
	);

	// A rank bump always directly follows a link write
	a_bump_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bump_wr |-> $past(cmd.link_wr))
		else $error("rank bump without preceding link");

	// No transfer is taken while the clearing pass still writes the table
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !in_ready)
		else $error("input ready during clearing pass");

	// A hop is only taken from a node that is not a root
	a_hop_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hop |-> !sts.at_root)
		else $error("walk stepped past a root");

	// Only queries produce results, and never into a full output register
	a_resp_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!sts.op_union && !sts.out_full))
		else $error("result loaded for union or over pending result");

endmodule

`default_nettype wire

FILE: tb/dsu_check_pkg.sv
package dsu_check_pkg;

	timeunit 1ns;
	timeprecision 1ps;

	import dsu_pkg::*;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_UNION = 1'b1
	} dsu_op_e;

	// One outstanding query answer, with the elements kept for the report
	typedef struct packed {
		elem_t first;
		elem_t second;
		logic  same;
	} answer_t;

	class connectivity_board;
		elem_t       link_of   [NUM_ELEMENTS];
		rank_t       height_of [NUM_ELEMENTS];
		answer_t     pending_answers[$];
		int unsigned mismatches;
		int unsigned queries;
		int unsigned unions;
		int unsigned links;
		int unsigned joined;
		int unsigned deepest;

		function new();
			for (int i = 0; i < NUM_ELEMENTS; i++) begin
				link_of[i]   = elem_t'(i);
				height_of[i] = '0;
			end
			mismatches = 0;
			queries    = 0;
			unions     = 0;
			links      = 0;
			joined     = 0;
			deepest    = 0;
		endfunction

		// Follow parent links up to the root; no path compression
		function elem_t climb_to_root(elem_t e);
			elem_t       up;
			int unsigned hops;
			hops = 0;
			while (hops < NUM_ELEMENTS) begin
				up = link_of[e];
				if (up == e || int'(up) >= NUM_ELEMENTS)
					break;
				e = up;
				hops++;
			end
			if (hops > deepest)
				deepest = hops;
			return e;
		endfunction

		function void note_transfer(dsu_op_e kind, elem_t a, elem_t b);
			elem_t ra;
			elem_t rb;
			logic  same;
			bit    fits;
			fits = int'(a) < NUM_ELEMENTS && int'(b) < NUM_ELEMENTS;
			if (kind == OP_QUERY) begin
				queries++;
				if (fits)
					same = (climb_to_root(a) == climb_to_root(b));
				else
					same = (a == b);
				if (same)
					joined++;
				pending_answers.push_back('{first: a, second: b, same: same});
				return;
			end
			unions++;
			// Elements without a table entry stay singletons
			if (!fits)
				return;
			ra = climb_to_root(a);
			rb = climb_to_root(b);
			if (ra == rb)
				return;
			links++;
			if (height_of[ra] < height_of[rb]) begin
				link_of[ra] = rb;
			end else if (height_of[rb] < height_of[ra]) begin
				link_of[rb] = ra;
			end else begin
				link_of[rb] = ra;
				if (height_of[ra] < RANK_MAX)
					height_of[ra]++;
			end
		endfunction

		function void check_answer(logic got);
			answer_t want;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%t: same_set expected no transfer, got %0b", $time, got);
				return;
			end
			want = pending_answers.pop_front();
			if (got !== want.same) begin
				mismatches++;
				$display("%t: query (%0d, %0d) same_set expected %0b, got %0b",
					$time, want.first, want.second, want.same, got);
			end
		endfunction
	endclass

endpackage

FILE: tb/disjoint_set_union_by_rank_test.sv
module disjoint_set_union_by_rank_test;

	timeunit 1ns;
	timeprecision 1ps;

	import dsu_pkg::*;
	import dsu_check_pkg::*;

	// Random part: item count, length of one element window, and the calm tail
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned WINDOW_ITEMS = 100;
	localparam int unsigned CALM_ITEMS   = 150;
	// The clearing pass after reset alone holds in_ready low while it writes
	// every entry; each item adds its root walks plus any gaps and stalls.
	localparam int unsigned STALL_LIMIT  = 5000;
	// Settle time after the last answer
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned ELEM_TOP      = (1 << ELEM_W) - 1;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid;
	logic  in_ready;
	logic  op;
	elem_t first_element;
	elem_t second_element;
	logic  out_valid;
	logic  out_ready;
	logic  same_set;

	// Set for the last part of the run: no gaps on either side
	bit quiet_tail;

	connectivity_board board;
	int unsigned       idle_run;

	disjoint_set_union_by_rank DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.first_element  (first_element),
		.second_element (second_element),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.same_set       (same_set)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Present one item at the falling edge and hold it until the transfer.
	// Valid is left high on return; the caller drops it only for a gap or a drain.
	task automatic send_item(dsu_op_e kind, elem_t a, elem_t b);
		@(negedge clk);
		in_valid       <= 1'b1;
		op             <= kind;
		first_element  <= a;
		second_element <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold off until every query answer has come back
	task automatic wait_for_answers();
		while (board.pending_answers.size() != 0)
			@(negedge clk);
	endtask

	// Mostly pick inside the current window so trees grow deep and queries
	// often land in a shared set; the rest spans the full field.
	function automatic elem_t pick_element(int unsigned base, int unsigned span);
		if ($urandom_range(0, 9) < 8)
			return elem_t'(base + $urandom_range(0, span - 1));
		return elem_t'($urandom_range(0, ELEM_TOP));
	endfunction

	// Both transfers are sampled at the rising edge. Answers are checked
	// before the new item is noted; an answer never belongs to an item
	// taken on the same edge, so the order only keeps the queue tidy.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_answer(same_set);
			if (in_valid && in_ready)
				board.note_transfer(dsu_op_e'(op), first_element, second_element);
		end
	end

	// Receiver: random stall bursts, with stall-free stretches
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Watchdog: the loop only exits when nothing has moved for too long
	initial begin
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned span;
		int unsigned base;
		bit          gapless;
		dsu_op_e     kind;
		elem_t       a;
		elem_t       b;

		board          = new();
		quiet_tail     = 1'b0;
		in_valid       = 1'b0;
		op             = OP_QUERY;
		first_element  = '0;
		second_element = '0;
		span           = 4;
		base           = 0;
		gapless        = 1'b0;

		// Hold reset, then release it away from the rising edge
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Fresh table: singletons answer only for themselves.
		send_item(OP_QUERY, 10'd0, 10'd0);
		send_item(OP_QUERY, 10'd0, 10'd1023);
		send_item(OP_QUERY, 10'd1023, 10'd1023);
		// Equal ranks: 1 goes under 0, rank of 0 grows
		send_item(OP_UNION, 10'd0, 10'd1);
		send_item(OP_QUERY, 10'd1, 10'd0);
		// Already in the same set: nothing changes, no answer
		send_item(OP_UNION, 10'd1, 10'd0);
		// Lower-rank root named first, twice: both end under 0
		send_item(OP_UNION, 10'd2, 10'd0);
		send_item(OP_UNION, 10'd3, 10'd2);
		// Build a rank-2 tree at the top end of the index range
		send_item(OP_UNION, 10'd1023, 10'd1022);
		send_item(OP_UNION, 10'd1021, 10'd1020);
		send_item(OP_UNION, 10'd1020, 10'd1023);
		// Rank-1 root under the rank-2 root, leaving two-hop walks on both sides
		send_item(OP_UNION, 10'd0, 10'd1022);
		send_item(OP_QUERY, 10'd3, 10'd1020);
		send_item(OP_QUERY, 10'd1022, 10'd2);
		// Alternating bit patterns on both fields
		send_item(OP_QUERY, 10'h2AA, 10'h155);
		send_item(OP_UNION, 10'h155, 10'h2AA);
		send_item(OP_QUERY, 10'h2AA, 10'h155);
		send_item(OP_UNION, 10'd512, 10'd511);
		send_item(OP_QUERY, 10'd512, 10'd1);
		send_item(OP_QUERY, 10'd0, 10'd3);
		send_item(OP_QUERY, 10'd511, 10'd511);

		// Sender waits out every pending answer before the random part
		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_answers();

		// Random part in windows of elements; each window picks a fresh
		// base and size so both shallow and deep forests show up.
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % WINDOW_ITEMS == 0) begin
				case ($urandom_range(0, 3))
					0: span = 4;
					1: span = 16;
					2: span = 64;
					default: span = 256;
				endcase
				base    = $urandom_range(0, NUM_ELEMENTS - span);
				gapless = ($urandom_range(0, 2) == 0);
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				quiet_tail = 1'b1;
			// Drain once more mid-run
			if (n == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait_for_answers();
			end

			kind = ($urandom_range(0, 99) < 45) ? OP_UNION : OP_QUERY;
			a    = pick_element(base, span);
			b    = pick_element(base, span);
			if ($urandom_range(0, 19) == 0)
				b = a;

			if (!quiet_tail && !gapless && $urandom_range(0, 4) == 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end
			send_item(kind, a, b);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_answers();
		// Catch any stray answer produced after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d queries (%0d same set) and %0d unions (%0d linked new roots);",
			board.queries, board.joined, board.unions, board.links);
		$display("deepest root walk %0d hops, with stalls on both sides of the handshake.",
			board.deepest);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
